FILE: rtl/cpd_pkg.sv
package cpd_pkg;

  // default price width in ticks of 0.0001
  localparam int unsigned PriceWidthDef = 32;

  // earlier candles kept per series, saturates at two
  localparam int unsigned HistWidth = 2;
  localparam logic [HistWidth-1:0] HistMax = HistWidth'(2);

  localparam int unsigned PatternWidth = 2;

  typedef enum logic [PatternWidth-1:0] {
    PAT_NONE      = 2'd0,
    PAT_HAMMER    = 2'd1,
    PAT_ENGULFING = 2'd2,
    PAT_MORNING   = 2'd3
  } pattern_e;

endpackage

FILE: rtl/candlestick_pattern_detector.sv
// Candlestick pattern detector. One candle (open, high, low, close, new-series flag)
// comes in per transaction and exactly one pattern code goes out for it, in order:
// 0 none, 1 hammer, 2 bullish engulfing, 3 morning star, tested in that priority.
// Prices are unsigned ticks of 0.0001, PriceWidth bits each; all ratio tests are
// exact integer compares. Throughput is one candle per clock with no gaps while
// m_axis_tready is high; the candle input register feeds the result register,
// with the pattern logic between them. Both registers move together under
// m_axis_tready, so a stalled result holds the candle behind it. A set start flag
// clears the history before the candle is judged, so only a hammer can fire on the
// first candle of a series; engulfing needs one earlier candle, morning star two.
module candlestick_pattern_detector #(
  parameter int unsigned PriceWidth = cpd_pkg::PriceWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // candle input
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // open_price, high_price, low_price, close_price (lowest bits first), zero pad
  input  logic [((4*PriceWidth+7)/8)*8-1:0]      s_axis_tdata,
  // start_series
  input  logic                                   s_axis_tuser,
  // pattern output
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // pattern in [1:0], zero pad
  output logic [7:0]                             m_axis_tdata
);
  import cpd_pkg::*;

  localparam int unsigned W = PriceWidth;

  // candle input register
  logic         cand_valid_q, cand_valid_d;
  logic [W-1:0] open_q, high_q, low_q, close_q;
  logic         start_q;

  // series history
  logic [W-1:0]         prev_open_q, prev_close_q, older_open_q, older_close_q;
  logic [HistWidth-1:0] hist_q, hist_eff, hist_next;

  // result register
  logic     res_valid_q, res_valid_d;
  pattern_e pattern_q, pattern_d;

  logic s_xfer, advance;

  // candle moves to the result register when that slot is free or being drained
  assign advance       = cand_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !cand_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // new series drops history before the candle is judged
  assign hist_eff  = start_q ? '0 : hist_q;
  assign hist_next = (hist_eff < HistMax) ? (hist_eff + HistWidth'(1)) : HistMax;

  cpd_eval #(
    .PriceWidth(W)
  ) u_eval (
    .open_i       (open_q),
    .high_i       (high_q),
    .low_i        (low_q),
    .close_i      (close_q),
    .prev_open_i  (prev_open_q),
    .prev_close_i (prev_close_q),
    .older_open_i (older_open_q),
    .older_close_i(older_close_q),
    .hist_i       (hist_eff),
    .pattern_o    (pattern_d)
  );

  always_comb begin
    cand_valid_d = s_xfer ? 1'b1 : (advance ? 1'b0 : cand_valid_q);
    res_valid_d  = advance ? 1'b1 : ((res_valid_q && m_axis_tready) ? 1'b0 : res_valid_q);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q  <= 1'b0;
      res_valid_q   <= 1'b0;
      hist_q        <= '0;
      prev_open_q   <= '0;
      prev_close_q  <= '0;
      older_open_q  <= '0;
      older_close_q <= '0;
    end else begin
      cand_valid_q <= cand_valid_d;
      res_valid_q  <= res_valid_d;
      if (advance) begin
        // shift the judged candle into history
        hist_q        <= hist_next;
        older_open_q  <= prev_open_q;
        older_close_q <= prev_close_q;
        prev_open_q   <= open_q;
        prev_close_q  <= close_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      open_q  <= s_axis_tdata[W-1:0];
      high_q  <= s_axis_tdata[2*W-1:W];
      low_q   <= s_axis_tdata[3*W-1:2*W];
      close_q <= s_axis_tdata[4*W-1:3*W];
      start_q <= s_axis_tuser;
    end
    if (advance) begin
      pattern_q <= pattern_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {{(8-PatternWidth){1'b0}}, pattern_q};

endmodule

FILE: rtl/cpd_eval.sv
module cpd_eval #(
  parameter int unsigned PriceWidth = cpd_pkg::PriceWidthDef
) (
  input  logic [PriceWidth-1:0]          open_i,
  input  logic [PriceWidth-1:0]          high_i,
  input  logic [PriceWidth-1:0]          low_i,
  input  logic [PriceWidth-1:0]          close_i,
  input  logic [PriceWidth-1:0]          prev_open_i,
  input  logic [PriceWidth-1:0]          prev_close_i,
  input  logic [PriceWidth-1:0]          older_open_i,
  input  logic [PriceWidth-1:0]          older_close_i,
  input  logic [cpd_pkg::HistWidth-1:0]  hist_i,
  output cpd_pkg::pattern_e              pattern_o
);
  import cpd_pkg::*;

  localparam int unsigned W = PriceWidth;

  // |a - b|
  function automatic logic [W-1:0] abs_diff(input logic [W-1:0] a, input logic [W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // 5*small <= 2*big, exact
  function automatic logic two_fifths(input logic [W-1:0] small_v, input logic [W-1:0] big_v);
    logic [W+2:0] lhs;
    logic [W+2:0] rhs;
    lhs = {1'b0, small_v, 2'b00} + {3'b000, small_v};
    rhs = {2'b00, big_v, 1'b0};
    two_fifths = (lhs <= rhs);
  endfunction

  logic [W-1:0] body_raw, body, top, bot, range_v;
  logic [W-1:0] older_body_raw, older_body, prev_body;
  logic         lower_ok, upper_ok, hammer_hit, is_engulf, is_morning;
  logic [W:0]   close_x2, older_sum;

  always_comb begin
    body_raw = abs_diff(close_i, open_i);
    body     = (body_raw == '0) ? W'(1) : body_raw;
    top      = (open_i > close_i) ? open_i : close_i;
    bot      = (open_i < close_i) ? open_i : close_i;
    range_v  = (high_i > low_i) ? (high_i - low_i) : W'(1);

    // negative lower shadow fails, negative upper shadow passes
    lower_ok = (bot >= low_i) && ({1'b0, bot - low_i} >= {body, 1'b0});
    upper_ok = (high_i <= top) || ((high_i - top) <= body);
    hammer_hit = lower_ok && upper_ok && two_fifths(body, range_v);

    is_engulf = (prev_close_i < prev_open_i) && (close_i > open_i) &&
                (open_i <= prev_close_i) && (close_i >= prev_open_i);

    older_body_raw = abs_diff(older_close_i, older_open_i);
    older_body     = (older_body_raw == '0) ? W'(1) : older_body_raw;
    prev_body      = abs_diff(prev_close_i, prev_open_i);
    close_x2       = {close_i, 1'b0};
    older_sum      = {1'b0, older_open_i} + {1'b0, older_close_i};
    is_morning = (older_close_i < older_open_i) && two_fifths(prev_body, older_body) &&
                 (close_i > open_i) && (close_x2 >= older_sum);

    if (hammer_hit) begin
      pattern_o = PAT_HAMMER;
    end else if ((hist_i >= HistWidth'(1)) && is_engulf) begin
      pattern_o = PAT_ENGULFING;
    end else if ((hist_i >= HistMax) && is_morning) begin
      pattern_o = PAT_MORNING;
    end else begin
      pattern_o = PAT_NONE;
    end
  end

endmodule
